FILE: hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SERVE  = 2'd1,
    OP_DUMP   = 2'd2
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic insert;
    logic serve;
    logic dump_first;
    logic dump_next;
  } cmd_t;

  typedef struct packed {
    logic last;
  } stat_t;

endpackage

FILE: hw/rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// ascending priority queue held in a shifting sorted register store
// ----------------------------------------------------------------------------
// One operation is accepted when the queue is idle. Insert and serve have two
// transfers: the transfer in, where every cell compares and shifts in
// parallel, and the result transfer out of the single result register. A dump
// gives one result per held entry, one per cycle while out_ready is high.
// Opcode 3 is taken and gives no result. Insert into a full queue is dropped
// with status full; serve or dump of an empty queue gives one result with
// status empty.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] item_priority,
  input  logic signed [31:0] item_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [15:0] out_priority,
  output logic signed [31:0] out_value,
  output logic [4:0]         entry_count,
  output logic               last
);

  cmd_t  cmd;
  stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .item_priority (item_priority),
    .item_value    (item_value),
    .stat          (stat),
    .status        (status),
    .out_priority  (out_priority),
    .out_value     (out_value),
    .entry_count   (entry_count),
    .last          (last)
  );

endmodule

FILE: hw/rtl/spq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// shifting sorted store, entry count, dump pointer and result register
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic signed [15:0] item_priority,
  input  logic signed [31:0] item_value,
  output stat_t              stat,
  output logic [1:0]         status,
  output logic signed [15:0] out_priority,
  output logic signed [31:0] out_value,
  output logic [4:0]         entry_count,
  output logic               last
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);

  logic signed [15:0] prio [QUEUE_DEPTH];
  logic signed [31:0] val  [QUEUE_DEPTH];
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      rd_idx;
  logic [QUEUE_DEPTH-1:0] gt;
  logic [QUEUE_DEPTH-1:0] land;
  logic               full;
  logic               empty;

  assign full   = (count == CW'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_idx = cmd.dump_next ? idx + IW'(1) : '0;
  assign stat.last = last;

  // per-cell compare: held and strictly greater moves up one place
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      gt[i] = (CW'(i) < count) && (prio[i] > item_priority);
    end
    land[0] = gt[0] || empty;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      land[i] = !gt[i-1] && (gt[i] || (CW'(i) == count));
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.insert && !full) begin
      count_next = count + CW'(1);
    end else if (cmd.serve && !empty) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && !full) begin
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (gt[i-1]) begin
          prio[i] <= prio[i-1];
          val[i]  <= val[i-1];
        end
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (land[i]) begin
          prio[i] <= item_priority;
          val[i]  <= item_value;
        end
      end
    end else if (cmd.serve && !empty) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        prio[i] <= prio[i+1];
        val[i]  <= val[i+1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      status       <= full ? ST_FULL : ST_OK;
      out_priority <= '0;
      out_value    <= '0;
      entry_count  <= 5'(count_next);
      last         <= 1'b1;
    end else if (cmd.serve) begin
      status       <= empty ? ST_EMPTY : ST_OK;
      out_priority <= empty ? 16'sd0 : prio[0];
      out_value    <= empty ? 32'sd0 : val[0];
      entry_count  <= 5'(count_next);
      last         <= 1'b1;
    end else if (cmd.dump_first) begin
      idx          <= '0;
      status       <= empty ? ST_EMPTY : ST_OK;
      out_priority <= empty ? 16'sd0 : prio[rd_idx];
      out_value    <= empty ? 32'sd0 : val[rd_idx];
      entry_count  <= 5'(count);
      last         <= empty || (count == CW'(1));
    end else if (cmd.dump_next) begin
      idx          <= rd_idx;
      status       <= ST_OK;
      out_priority <= prio[rd_idx];
      out_value    <= val[rd_idx];
      entry_count  <= 5'(count);
      last         <= (CW'(idx) + CW'(2) == count);
    end
  end

endmodule

FILE: hw/rtl/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// handshake controller: decodes operations and sequences dump results
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  output logic       out_valid,
  input  logic       out_ready,
  output cmd_t       cmd,
  input  stat_t      stat
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (op_t'(opcode))
            OP_INSERT: begin
              cmd.insert = 1'b1;
              state_next = S_RESP;
            end
            OP_SERVE: begin
              cmd.serve  = 1'b1;
              state_next = S_RESP;
            end
            OP_DUMP: begin
              cmd.dump_first = 1'b1;
              state_next     = S_RESP;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.dump_next = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks for the sorted priority queue
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         opcode,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic signed [15:0] out_priority,
  input logic signed [31:0] out_value,
  input logic [4:0]         entry_count,
  input logic               last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(out_priority) && $stable(out_value) && $stable(entry_count) &&
      $stable(last))
    else $error("result changed while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_op_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready &&
      (opcode == OP_INSERT || opcode == OP_SERVE || opcode == OP_DUMP)
      |=> out_valid)
    else $error("no result after operation transfer");

  a_dump_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && !in_ready)
    else $error("dump ended before last entry");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last)
    else $error("error status not on final result");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .opcode       (opcode),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .out_priority (out_priority),
  .out_value    (out_value),
  .entry_count  (entry_count),
  .last         (last)
);
